[hw/rtl/geoenc_pkg.sv]
// ----------------------------------------------------------------------------
// geoenc_pkg: shared constants and functions of the geohash encoder
// Fixed-point limits, field widths and the base32 character table.
// ----------------------------------------------------------------------------
`default_nettype none

package geoenc_pkg;

  // Field widths
  localparam int LatW   = 39;
  localparam int LonW   = 40;
  localparam int OffW   = 40;   // offset-domain coordinate width
  localparam int CodeW  = 60;
  localparam int SymW   = 5;
  localparam int CharW  = 7;
  localparam int PrecW  = 4;
  localparam int StepW  = 6;

  localparam logic [PrecW-1:0] MaxChars   = 4'd12;
  localparam logic [PrecW-1:0] PrecReset  = 4'd12;

  // Saturation limits, 31 fraction bits, signed 41-bit domain
  localparam logic signed [OffW:0] LatLim = 41'sd193273528320;  // 90 deg
  localparam logic signed [OffW:0] LonLim = 41'sd386547056640;  // 180 deg

  // Full spans in the offset domain
  localparam logic [OffW-1:0] LatSpan = 40'd386547056640;       // 180 deg
  localparam logic [OffW-1:0] LonSpan = 40'd773094113280;       // 360 deg

  // Geohash base32 alphabet, ASCII
  localparam logic [CharW-1:0] B32Table [32] = '{
    7'd48,  7'd49,  7'd50,  7'd51,  7'd52,  7'd53,  7'd54,  7'd55,
    7'd56,  7'd57,  7'd98,  7'd99,  7'd100, 7'd101, 7'd102, 7'd103,
    7'd104, 7'd106, 7'd107, 7'd109, 7'd110, 7'd112, 7'd113, 7'd114,
    7'd115, 7'd116, 7'd117, 7'd118, 7'd119, 7'd120, 7'd121, 7'd122
  };

  function automatic logic [CharW-1:0] b32_char(input logic [SymW-1:0] sym);
    return B32Table[sym];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/geohash_encoder_top.sv]
// ----------------------------------------------------------------------------
// geohash_encoder_top: geohash encoder, coordinate pair to base32 characters
// Saturates latitude and longitude, bisects both axes with one shared
// midpoint adder and comparator, then emits one character word per symbol.
// ----------------------------------------------------------------------------
// Operation: after input accept, 5*P bisection steps, where P is the clamped
// precision (1..12), one bisection step per cycle in the shared midpoint
// unit; then P characters, one per cycle while the output is not stalled.
// A new pair is not accepted until the last character of the current pair
// has been emitted.
// Reset: asynchronous, active low; returns to idle, precision becomes 12.
`default_nettype none

module geohash_encoder_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Input channel
  input  wire logic                                in_valid_i,
  output      logic                                in_stall_o,
  input  wire logic signed [geoenc_pkg::LatW-1:0]  latitude_i,
  input  wire logic signed [geoenc_pkg::LonW-1:0]  longitude_i,
  // Configuration channel
  input  wire logic                                cfg_valid_i,
  output      logic                                cfg_ready_o,
  input  wire logic [geoenc_pkg::PrecW-1:0]        cfg_precision_i,
  // Output channel
  output      logic                                out_valid_o,
  input  wire logic                                out_stall_i,
  output      logic [geoenc_pkg::SymW-1:0]         symbol_o,
  output      logic [geoenc_pkg::CharW-1:0]        char_code_o,
  output      logic [geoenc_pkg::CodeW-1:0]        code_value_o,
  output      logic                                last_o
);

  typedef enum logic [1:0] {
    StIdle,
    StEnc,
    StEmit
  } state_e;

  state_e                          state_q;
  logic [geoenc_pkg::PrecW-1:0]    prec_q;
  logic [geoenc_pkg::PrecW-1:0]    nch_q;
  logic [geoenc_pkg::StepW-1:0]    nbits_q;
  logic [geoenc_pkg::StepW-1:0]    step_q;
  logic [geoenc_pkg::PrecW-1:0]    chr_q;
  logic [geoenc_pkg::OffW-1:0]     ulat_q, ulon_q;
  logic [geoenc_pkg::OffW-1:0]     lat_lo_q, lat_hi_q, lon_lo_q, lon_hi_q;
  logic [geoenc_pkg::CodeW-1:0]    code_q;
  logic [geoenc_pkg::CodeW-1:0]    sym_sr_q;

  // Handshakes
  logic in_acc, out_free;
  assign in_stall_o  = (state_q != StIdle);
  assign cfg_ready_o = (state_q == StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_o || !out_stall_i;

  // Saturate and move inputs into the non-negative offset domain
  logic signed [geoenc_pkg::OffW:0] lat_s, lon_s, lat_c, lon_c;
  logic        [geoenc_pkg::OffW:0] ulat_w, ulon_w;
  always_comb begin
    lat_s = (geoenc_pkg::OffW + 1)'(latitude_i);
    lon_s = (geoenc_pkg::OffW + 1)'(longitude_i);
    if (lat_s > geoenc_pkg::LatLim) begin
      lat_c = geoenc_pkg::LatLim;
    end else if (lat_s < -geoenc_pkg::LatLim) begin
      lat_c = -geoenc_pkg::LatLim;
    end else begin
      lat_c = lat_s;
    end
    if (lon_s > geoenc_pkg::LonLim) begin
      lon_c = geoenc_pkg::LonLim;
    end else if (lon_s < -geoenc_pkg::LonLim) begin
      lon_c = -geoenc_pkg::LonLim;
    end else begin
      lon_c = lon_s;
    end
    ulat_w = unsigned'(lat_c + geoenc_pkg::LatLim);
    ulon_w = unsigned'(lon_c + geoenc_pkg::LonLim);
  end

  // Clamp precision and derive the bit count
  logic [geoenc_pkg::PrecW-1:0] nch_w;
  logic [geoenc_pkg::StepW-1:0] nbits_w;
  always_comb begin
    if (prec_q == '0) begin
      nch_w = 4'd1;
    end else if (prec_q > geoenc_pkg::MaxChars) begin
      nch_w = geoenc_pkg::MaxChars;
    end else begin
      nch_w = prec_q;
    end
    nbits_w = geoenc_pkg::StepW'({nch_w, 2'b00}) + geoenc_pkg::StepW'(nch_w);
  end

  // Shared bisection unit: even steps longitude, odd steps latitude
  logic                          axis_lat, ge;
  logic [geoenc_pkg::OffW-1:0]   lo_w, hi_w, val_w, mid_w;
  logic [geoenc_pkg::OffW:0]     sum_w;
  logic [geoenc_pkg::CodeW-1:0]  code_w;
  always_comb begin
    axis_lat = step_q[0];
    lo_w     = axis_lat ? lat_lo_q : lon_lo_q;
    hi_w     = axis_lat ? lat_hi_q : lon_hi_q;
    val_w    = axis_lat ? ulat_q   : ulon_q;
    sum_w    = {1'b0, lo_w} + {1'b0, hi_w};
    mid_w    = sum_w[geoenc_pkg::OffW:1];
    ge       = (val_w >= mid_w);
    code_w   = code_q | (ge ? (geoenc_pkg::CodeW'(1) << step_q) : '0);
  end

  // Sequencer, datapath and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      prec_q       <= geoenc_pkg::PrecReset;
      nch_q        <= '0;
      nbits_q      <= '0;
      step_q       <= '0;
      chr_q        <= '0;
      ulat_q       <= '0;
      ulon_q       <= '0;
      lat_lo_q     <= '0;
      lat_hi_q     <= geoenc_pkg::LatSpan;
      lon_lo_q     <= '0;
      lon_hi_q     <= geoenc_pkg::LonSpan;
      code_q       <= '0;
      sym_sr_q     <= '0;
      out_valid_o  <= 1'b0;
      symbol_o     <= '0;
      char_code_o  <= '0;
      code_value_o <= '0;
      last_o       <= 1'b0;
    end else begin
      // Take the precision register write
      if (cfg_valid_i && cfg_ready_o) begin
        prec_q <= cfg_precision_i;
      end
      // Drop the output word once taken; the emit state reloads it itself
      if (out_valid_o && !out_stall_i && state_q != StEmit) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            ulat_q   <= ulat_w[geoenc_pkg::OffW-1:0];
            ulon_q   <= ulon_w[geoenc_pkg::OffW-1:0];
            lat_lo_q <= '0;
            lat_hi_q <= geoenc_pkg::LatSpan;
            lon_lo_q <= '0;
            lon_hi_q <= geoenc_pkg::LonSpan;
            code_q   <= '0;
            step_q   <= '0;
            nch_q    <= nch_w;
            nbits_q  <= nbits_w;
            state_q  <= StEnc;
          end
        end
        StEnc: begin
          // Advance one bisection step on the selected axis
          if (axis_lat) begin
            if (ge) lat_lo_q <= mid_w;
            else    lat_hi_q <= mid_w;
          end else begin
            if (ge) lon_lo_q <= mid_w;
            else    lon_hi_q <= mid_w;
          end
          code_q <= code_w;
          step_q <= step_q + 6'd1;
          if (step_q == nbits_q - 6'd1) begin
            sym_sr_q <= code_w;
            chr_q    <= '0;
            state_q  <= StEmit;
          end
        end
        StEmit: begin
          // Emit one character word whenever the output register is free
          if (out_free) begin
            out_valid_o  <= 1'b1;
            symbol_o     <= sym_sr_q[geoenc_pkg::SymW-1:0];
            char_code_o  <= geoenc_pkg::b32_char(sym_sr_q[geoenc_pkg::SymW-1:0]);
            code_value_o <= code_q;
            last_o       <= (chr_q == nch_q - 4'd1);
            sym_sr_q     <= sym_sr_q >> geoenc_pkg::SymW;
            chr_q        <= chr_q + 4'd1;
            if (chr_q == nch_q - 4'd1) begin
              state_q <= StIdle;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // An accepted pair keeps the input stalled on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // The step counter never runs past the bit count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StEnc |-> step_q < nbits_q)
    else $error("bisection step beyond bit count");

  // The character code always matches its symbol
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> char_code_o == geoenc_pkg::b32_char(symbol_o))
    else $error("character code does not match symbol");

  // Characters of a pair stop at the clamped precision
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StEmit |-> chr_q < nch_q)
    else $error("character count beyond precision");
`endif

endmodule

`default_nettype wire
